// File: design/spts_pkg.sv
// Package for the sphere point transform and shade block.
// Holds constants, register indexes, hue sector codes and a helper function.
// No dependencies.
`timescale 1ns / 1ps

package spts_pkg;

    // Sphere geometry and point set
    localparam int RADIUS      = 130;
    localparam int POINT_COUNT = 600;

    // Port widths
    localparam int UNIT_W     = 16;
    localparam int NUMBER_W   = 10;
    localparam int CENTRE_W   = 13;
    localparam int HUE_BASE_W = 16;
    localparam int PIX_W      = 15;
    localparam int DOT_W      = 4;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Pipeline depth, input transaction to result register
    localparam int PIPE_DEPTH = 7;

    // Pixel saturation limits and working width before saturation
    localparam int PIX_MIN    = -1024;
    localparam int PIX_MAX    = 9215;
    localparam int PIX_CALC_W = 18;

    // Dot size: 2 plus one step per radius third, six steps at most
    localparam int DOT_MIN   = 2;
    localparam int DOT_MAX   = 8;
    localparam int DOT_STEPS = DOT_MAX - DOT_MIN;
    localparam int DOT_LOW_C = -2;

    // Visible when 10*z > -7*R (z in pixel units)
    localparam int VIS_LIMIT = -7 * RADIUS;

    // Hue: one sector spans 65536*POINT_COUNT/6 units of the scaled hue
    localparam int HUE_W           = 27;
    localparam int HUE_REM_W       = 23;
    localparam int HUE_SECTOR      = 65536 * POINT_COUNT / 6;
    localparam int HUE_WRAP_MAX    = ((2 ** NUMBER_W - 1) * 65536
                                      + (2 ** HUE_BASE_W - 1) * POINT_COUNT) / HUE_SECTOR;
    localparam int SECTOR_DIV      = POINT_COUNT / 6;
    localparam int HUE_RECIP_SHIFT = 19;
    localparam int HUE_RECIP       = (2 ** HUE_RECIP_SHIFT) / SECTOR_DIV + 1;
    localparam int RAMP_W          = 15;
    localparam int QUOT_W          = 28;
    localparam int CHAN_FULL       = 255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COS_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_BASE = 3'd6;

    // Register reset values
    localparam logic signed [UNIT_W-1:0] COS_RESET    = 16'sd16384;
    localparam logic signed [UNIT_W-1:0] SIN_RESET    = 16'sd0;
    localparam logic [CENTRE_W-1:0]      CENTRE_RESET = 13'd150;
    localparam logic [HUE_BASE_W-1:0]    HUE_RESET    = 16'd0;

    // Hue sector codes, named by the color pair they blend
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    // Clamp a whole-pixel value to the screen range
    function automatic logic signed [PIX_W-1:0] pix_saturate(
        input logic signed [PIX_CALC_W-1:0] p
    );
        logic signed [PIX_W-1:0] r;
        if (p < PIX_CALC_W'(PIX_MIN))
            r = PIX_W'(PIX_MIN);
        else if (p > PIX_CALC_W'(PIX_MAX))
            r = PIX_W'(PIX_MAX);
        else
            r = PIX_W'(p);
        return r;
    endfunction

endpackage

// File: design/sphere_point_transform_shade.sv
// Sphere point transform and shade: rotation, projection, depth cues and hue color.
// Single module, seven register stages; depends on spts_pkg.
`timescale 1ns / 1ps

// One point per clock while the output side is not stalled. The pipeline runs
// two rounds of rotation multiplies (about X, then about Y),
// each followed by its sum, then the wide translate/depth adds and final rounding.
// The whole pipeline advances together: it holds while a result waits at the output
// register, and point_ready follows result_ready in that case. Configuration is
// sampled live by the stages, so write it only while no transaction is in flight.
module sphere_point_transform_shade
    import spts_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // point channel
    input  logic                         point_valid,
    output logic                         point_ready,
    input  logic signed [UNIT_W-1:0]     unit_x,
    input  logic signed [UNIT_W-1:0]     unit_y,
    input  logic signed [UNIT_W-1:0]     unit_z,
    input  logic [NUMBER_W-1:0]          point_number,
    // result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [PIX_W-1:0]      pixel_x,
    output logic signed [PIX_W-1:0]      pixel_y,
    output logic [DOT_W-1:0]             dot_size,
    output logic                         visible,
    output logic [CHAN_W-1:0]            red,
    output logic [CHAN_W-1:0]            green,
    output logic [CHAN_W-1:0]            blue,
    // configuration write port
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [UNIT_W-1:0]  cos_x_reg;
    logic signed [UNIT_W-1:0]  sin_x_reg;
    logic signed [UNIT_W-1:0]  cos_y_reg;
    logic signed [UNIT_W-1:0]  sin_y_reg;
    logic [CENTRE_W-1:0]       centre_x_reg;
    logic [CENTRE_W-1:0]       centre_y_reg;
    logic [HUE_BASE_W-1:0]     hue_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_x_reg    <= COS_RESET;
            sin_x_reg    <= SIN_RESET;
            cos_y_reg    <= COS_RESET;
            sin_y_reg    <= SIN_RESET;
            centre_x_reg <= CENTRE_RESET;
            centre_y_reg <= CENTRE_RESET;
            hue_base_reg <= HUE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COS_X:    cos_x_reg    <= signed'(cfg_data);
                REG_SIN_X:    sin_x_reg    <= signed'(cfg_data);
                REG_COS_Y:    cos_y_reg    <= signed'(cfg_data);
                REG_SIN_Y:    sin_y_reg    <= signed'(cfg_data);
                REG_CENTRE_X: centre_x_reg <= cfg_data[CENTRE_W-1:0];
                REG_CENTRE_Y: centre_y_reg <= cfg_data[CENTRE_W-1:0];
                REG_HUE_BASE: hue_base_reg <= cfg_data[HUE_BASE_W-1:0];
                default:      ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves together
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  pipe_en;

    assign pipe_en      = !valid_reg[PIPE_DEPTH-1] || result_ready;
    assign point_ready  = pipe_en;
    assign result_valid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (pipe_en)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], point_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: scale by radius, combine hue base and point offset
    // ------------------------------------------------------------------
    logic signed [23:0]  xs_reg, ys_reg, zs_reg;
    logic [HUE_W-1:0]    hue_full_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            xs_reg       <= 24'(unit_x) * 24'(RADIUS);
            ys_reg       <= 24'(unit_y) * 24'(RADIUS);
            zs_reg       <= 24'(unit_z) * 24'(RADIUS);
            hue_full_reg <= HUE_W'({point_number, 16'b0})
                            + HUE_W'(hue_base_reg) * HUE_W'(POINT_COUNT);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: X rotation products; hue sector and remainder
    // ------------------------------------------------------------------
    logic signed [39:0]     ycx_reg, zsx_reg, ysx_reg, zcx_reg, xcy_s2_reg, xsy_s2_reg;
    logic [HUE_REM_W-1:0]   hue_rem_reg;
    logic [2:0]             hue_sec_s2_reg;
    logic [HUE_W-1:0]       hue_offset;
    logic [2:0]             hue_sec_next;
    logic [HUE_REM_W-1:0]   hue_rem_next;

    // thresholds are monotone, so the last one passed picks offset and sector
    always_comb
    begin
        hue_offset   = '0;
        hue_sec_next = SEC_RED_YEL;
        for (int k = 1; k <= HUE_WRAP_MAX; k++)
        begin
            if (hue_full_reg >= HUE_W'(k * HUE_SECTOR))
            begin
                hue_offset   = HUE_W'(k * HUE_SECTOR);
                hue_sec_next = 3'(k % 6);
            end
        end
        hue_rem_next = HUE_REM_W'(hue_full_reg - hue_offset);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            ycx_reg        <= ys_reg * cos_x_reg;
            zsx_reg        <= zs_reg * sin_x_reg;
            ysx_reg        <= ys_reg * sin_x_reg;
            zcx_reg        <= zs_reg * cos_x_reg;
            xcy_s2_reg     <= xs_reg * cos_y_reg;
            xsy_s2_reg     <= xs_reg * sin_y_reg;
            hue_rem_reg    <= hue_rem_next;
            hue_sec_s2_reg <= hue_sec_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: X rotation sums; hue ramps scaled to channel range
    // ------------------------------------------------------------------
    logic signed [40:0]    y28_reg, z28_reg;
    logic signed [39:0]    xcy_s3_reg, xsy_s3_reg;
    logic [RAMP_W-1:0]     ramp_up_reg, ramp_dn_reg;
    logic [2:0]            hue_sec_s3_reg;
    logic [HUE_REM_W-1:0]  hue_fall;

    assign hue_fall = HUE_REM_W'(HUE_SECTOR) - hue_rem_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            y28_reg        <= 41'(ycx_reg) - 41'(zsx_reg);
            z28_reg        <= 41'(ysx_reg) + 41'(zcx_reg);
            xcy_s3_reg     <= xcy_s2_reg;
            xsy_s3_reg     <= xsy_s2_reg;
            ramp_up_reg    <= RAMP_W'((31'(hue_rem_reg) * 31'(CHAN_FULL)) >> 16);
            ramp_dn_reg    <= RAMP_W'((31'(hue_fall) * 31'(CHAN_FULL)) >> 16);
            hue_sec_s3_reg <= hue_sec_s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: Y rotation products; pixel_y; divide ramps by reciprocal
    // ------------------------------------------------------------------
    logic signed [56:0]           z28sy_reg, z28cy_reg;
    logic signed [39:0]           xcy_s4_reg, xsy_s4_reg;
    logic signed [PIX_W-1:0]      py_s4_reg;
    logic [QUOT_W-1:0]            quot_up_reg, quot_dn_reg;
    logic [2:0]                   hue_sec_s4_reg;
    logic signed [42:0]           vy;
    logic signed [PIX_CALC_W-1:0] py_trunc;

    // y = trunc((y28 + centre_y * 2^28) / 2^28), toward zero
    always_comb
    begin
        vy       = 43'(y28_reg) + signed'({2'b0, centre_y_reg, 28'b0});
        py_trunc = PIX_CALC_W'(vy >>> 28)
                   + ((vy[42] && (|vy[27:0])) ? PIX_CALC_W'(1) : PIX_CALC_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            z28sy_reg      <= z28_reg * sin_y_reg;
            z28cy_reg      <= z28_reg * cos_y_reg;
            xcy_s4_reg     <= xcy_s3_reg;
            xsy_s4_reg     <= xsy_s3_reg;
            py_s4_reg      <= pix_saturate(py_trunc);
            quot_up_reg    <= QUOT_W'(ramp_up_reg) * QUOT_W'(HUE_RECIP);
            quot_dn_reg    <= QUOT_W'(ramp_dn_reg) * QUOT_W'(HUE_RECIP);
            hue_sec_s4_reg <= hue_sec_s3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Y rotation sums; color from sector
    // ------------------------------------------------------------------
    logic signed [57:0]       x42_reg, z42_reg;
    logic signed [PIX_W-1:0]  py_s5_reg;
    logic [CHAN_W-1:0]        red_s5_reg, green_s5_reg, blue_s5_reg;
    logic [CHAN_W-1:0]        chan_up, chan_dn;
    logic [CHAN_W-1:0]        red_next, green_next, blue_next;

    always_comb
    begin
        chan_up = CHAN_W'(quot_up_reg >> HUE_RECIP_SHIFT);
        chan_dn = CHAN_W'(quot_dn_reg >> HUE_RECIP_SHIFT);
        case (hue_sec_s4_reg)
            SEC_RED_YEL:
            begin
                red_next = CHAN_W'(CHAN_FULL); green_next = chan_up; blue_next = '0;
            end
            SEC_YEL_GRN:
            begin
                red_next = chan_dn; green_next = CHAN_W'(CHAN_FULL); blue_next = '0;
            end
            SEC_GRN_CYN:
            begin
                red_next = '0; green_next = CHAN_W'(CHAN_FULL); blue_next = chan_up;
            end
            SEC_CYN_BLU:
            begin
                red_next = '0; green_next = chan_dn; blue_next = CHAN_W'(CHAN_FULL);
            end
            SEC_BLU_MAG:
            begin
                red_next = chan_up; green_next = '0; blue_next = CHAN_W'(CHAN_FULL);
            end
            default:
            begin
                red_next = CHAN_W'(CHAN_FULL); green_next = '0; blue_next = chan_dn;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x42_reg      <= 58'(z28sy_reg) + (58'(xcy_s4_reg) <<< 14);
            z42_reg      <= 58'(z28cy_reg) - (58'(xsy_s4_reg) <<< 14);
            py_s5_reg    <= py_s4_reg;
            red_s5_reg   <= red_next;
            green_s5_reg <= green_next;
            blue_s5_reg  <= blue_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: translate x; depth scaled by 3 and by 10
    // ------------------------------------------------------------------
    logic signed [58:0]       vx_reg;
    logic signed [59:0]       z3_reg;
    logic signed [61:0]       z10_reg;
    logic signed [PIX_W-1:0]  py_s6_reg;
    logic [CHAN_W-1:0]        red_s6_reg, green_s6_reg, blue_s6_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            vx_reg       <= 59'(x42_reg) + signed'({4'b0, centre_x_reg, 42'b0});
            z3_reg       <= 60'(z42_reg) + (60'(z42_reg) <<< 1);
            z10_reg      <= (62'(z42_reg) <<< 3) + (62'(z42_reg) <<< 1);
            py_s6_reg    <= py_s5_reg;
            red_s6_reg   <= red_s5_reg;
            green_s6_reg <= green_s5_reg;
            blue_s6_reg  <= blue_s5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: round x, dot size, visibility; result register
    // ------------------------------------------------------------------
    logic signed [PIX_W-1:0]      pixel_x_reg, pixel_y_reg;
    logic [DOT_W-1:0]             dot_size_reg;
    logic                         visible_reg;
    logic [CHAN_W-1:0]            red_reg, green_reg, blue_reg;
    logic signed [PIX_CALC_W-1:0] px_trunc;
    logic signed [17:0]           depth3;
    logic signed [19:0]           depth10;
    logic [DOT_W-1:0]             dot_next;
    logic                         visible_next;

    always_comb
    begin
        px_trunc = PIX_CALC_W'(vx_reg >>> 42)
                   + ((vx_reg[58] && (|vx_reg[41:0])) ? PIX_CALC_W'(1) : PIX_CALC_W'(0));
        // floor(3z) against multiples of R: one dot step per threshold passed
        depth3   = 18'(z3_reg >>> 42);
        dot_next = DOT_W'(DOT_MIN);
        for (int c = 0; c < DOT_STEPS; c++)
        begin
            if (depth3 >= 18'((c + DOT_LOW_C) * RADIUS))
                dot_next = dot_next + DOT_W'(1);
        end
        // strict compare: on the exact limit only a nonzero fraction passes
        depth10      = 20'(z10_reg >>> 42);
        visible_next = (depth10 > 20'(VIS_LIMIT))
                       || ((depth10 == 20'(VIS_LIMIT)) && (|z10_reg[41:0]));
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pixel_x_reg  <= pix_saturate(px_trunc);
            pixel_y_reg  <= py_s6_reg;
            dot_size_reg <= dot_next;
            visible_reg  <= visible_next;
            red_reg      <= red_s6_reg;
            green_reg    <= green_s6_reg;
            blue_reg     <= blue_s6_reg;
        end
    end

    assign pixel_x  = pixel_x_reg;
    assign pixel_y  = pixel_y_reg;
    assign dot_size = dot_size_reg;
    assign visible  = visible_reg;
    assign red      = red_reg;
    assign green    = green_reg;
    assign blue     = blue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a stalled result freezes the valid bits of every stage
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while result stalled");

    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (dot_size >= DOT_W'(DOT_MIN) && dot_size <= DOT_W'(DOT_MAX)))
        else $error("dot size out of range");

    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pixel_x >= PIX_W'(PIX_MIN) && pixel_x <= PIX_W'(PIX_MAX)
                          && pixel_y >= PIX_W'(PIX_MIN) && pixel_y <= PIX_W'(PIX_MAX)))
        else $error("pixel out of screen range");

    // every hue sector has one full and one empty channel
    a_hue_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((red == CHAN_W'(CHAN_FULL) || green == CHAN_W'(CHAN_FULL)
                           || blue == CHAN_W'(CHAN_FULL))
                          && (red == '0 || green == '0 || blue == '0)))
        else $error("color lacks a full or an empty channel");

endmodule
